FILE: design/square_sine_tone_synth_assert.svh
// assertion macros for the square/sine tone synthesizer
// no dependencies; included by the top level, which provides aclk and aresetn
`ifndef SQUARE_SINE_TONE_SYNTH_ASSERT_SVH
`define SQUARE_SINE_TONE_SYNTH_ASSERT_SVH
`ifndef SYNTHESIS
`define SST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sst: implication check failed");
`define SST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sst: next-cycle check failed");
`else
`define SST_ASSERT_IMP(lbl, ante, cons)
`define SST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/sst_pkg.sv
// shared types and constants of the square/sine tone synthesizer
// no dependencies; used by sst_front, sst_back and square_sine_tone_synth
package sst_pkg;

    // op codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_PHASE_SCALE   = 2'd1;
    localparam logic [1:0] REG_SQUARE_SHARE  = 2'd2;
    localparam logic [1:0] REG_VOLUME        = 2'd3;

    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic        RST_SAMPLE_FORMAT = 1'b1;
    localparam logic [23:0] RST_PHASE_SCALE   = 24'd97391;
    localparam logic [15:0] RST_SQUARE_SHARE  = 16'd16384;
    localparam logic [15:0] RST_VOLUME        = 16'd32768;

    // sample format codes
    localparam logic FMT_U8  = 1'b0;
    localparam logic FMT_S16 = 1'b1;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // odd degree-9 sine polynomial, q30
    localparam logic [30:0] SQ_C1 = 31'd1686629713;
    localparam logic [30:0] SQ_C3 = 31'd693598668;
    localparam logic [30:0] SQ_C5 = 31'd85569306;
    localparam logic [30:0] SQ_C7 = 31'd5026995;
    localparam logic [30:0] SQ_C9 = 31'd172272;
    localparam logic [30:0] HORNER_COEF [4] = '{SQ_C7, SQ_C5, SQ_C3, SQ_C1};

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    typedef struct packed {
        logic        is_load;
        logic [15:0] frequency;
        logic [23:0] tone_length;
        logic [23:0] pause_length;
    } sst_cmd_t;

    typedef struct packed {
        logic [QUEUE_AW:0] level;
        logic              full;
    } sst_front_st_t;

    typedef struct packed {
        logic idle;
        logic tone_pending;
        logic pause_pending;
    } sst_back_st_t;

endpackage

FILE: design/sst_front.sv
// front end: accepts input items, decodes the op and queues commands
// depends on sst_pkg
module sst_front
    import sst_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic [15:0]   s_frequency,
    input  logic [23:0]   s_tone_length,
    input  logic [23:0]   s_pause_length,
    output sst_cmd_t      q_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output sst_front_st_t front_st
);

    sst_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   level_reg, level_next;
    logic                push, pop;
    sst_cmd_t            cmd_in;

    always_comb begin
        cmd_in.is_load      = (s_op == OP_LOAD);
        cmd_in.frequency    = s_frequency;
        cmd_in.tone_length  = s_tone_length;
        cmd_in.pause_length = s_pause_length;
    end

    assign s_ready = (level_reg != QUEUE_FULL);
    assign q_valid = (level_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    assign front_st.level = level_reg;
    assign front_st.full  = !s_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: design/sst_back.sv
// back end: tone state, sine polynomial on a shared multiplier, blend, gain,
// sample formatting and the output register; depends on sst_pkg
module sst_back
    import sst_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sst_cmd_t           q_cmd,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic               sample_format,
    input  logic [23:0]        phase_scale,
    input  logic [15:0]        square_share,
    input  logic [15:0]        volume,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic               m_in_pause,
    output logic               m_last,
    output sst_back_st_t       back_st
);

    localparam int QB = TABLE_ADDR_BITS - 2;
    localparam logic [QB:0] QSIZE = (QB + 1)'(1) << QB;
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQR    = 7'b0000010,
        ST_HORNER = 7'b0000100,
        ST_ROOT   = 7'b0001000,
        ST_BLEND  = 7'b0010000,
        ST_GAIN   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [COUNT_BITS-1:0] tone_left_reg, tone_left_next;
    logic [COUNT_BITS-1:0] pause_left_reg, pause_left_next;
    logic [1:0]            step_reg, step_next;

    // datapath registers
    logic [30:0]        x_reg, x_next;
    logic [30:0]        x2_reg, x2_next;
    logic [30:0]        h_reg, h_next;
    logic               neg_half_reg, neg_half_next;
    logic [15:0]        s_mag_reg, s_mag_next;
    logic signed [31:0] m_reg, m_next;
    logic [45:0]        v_mag_reg, v_mag_next;
    logic               v_neg_reg, v_neg_next;
    logic               res_pause_reg, res_pause_next;
    logic               res_last_reg, res_last_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_sample_reg, m_sample_next;
    logic               m_in_pause_reg, m_in_pause_next;
    logic               m_last_reg, m_last_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [1:0]                 quad;
    logic [QB:0]                p_adj;
    logic [32:0]                tone33, pause33;
    logic [32:0]                rnd;
    logic [17:0]                rq;
    logic [15:0]                share_c, vol_c;
    logic [16:0]                wsin;
    logic signed [31:0]         term_sq, term_sin;
    logic [31:0]                m_abs;
    logic [60:0]                t16;
    logic [52:0]                t8;
    logic [15:0]                q16;
    logic [7:0]                 q8;
    logic signed [9:0]          u8;
    logic [15:0]                s16_val;
    logic [15:0]                s8_val;
    logic                       out_free;

    assign prod = mul_a * mul_b;

    assign addr  = phase_acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign quad  = addr[TABLE_ADDR_BITS-1 -: 2];
    assign p_adj = quad[0] ? QSIZE - {1'b0, addr[QB-1:0]} : {1'b0, addr[QB-1:0]};

    assign tone33  = 33'(q_cmd.tone_length);
    assign pause33 = 33'(q_cmd.pause_length);

    assign share_c = (square_share > ONE_Q15) ? ONE_Q15 : square_share;
    assign vol_c   = (volume > ONE_Q15) ? ONE_Q15 : volume;
    assign wsin    = 17'(ONE_Q15) - 17'(share_c);

    // square term follows the sign of the sine, zero counts as negative
    assign term_sq  = $signed({1'b0, share_c, 15'd0});
    assign term_sin = $signed({1'b0, prod[30:0]});
    assign m_abs    = m_reg[31] ? 32'(-m_reg) : 32'(m_reg);

    // rounding of the q30 sine to q15
    assign rnd = 33'(prod[61:30]) + 33'd16384;
    assign rq  = rnd[32:15];

    // 32767*v and 127*v by shift and subtract
    assign t16 = {v_mag_reg, 15'd0} - 61'(v_mag_reg);
    assign t8  = {v_mag_reg, 7'd0} - 53'(v_mag_reg);
    assign q16 = t16[60:45];
    assign q8  = (v_neg_reg && (t8[44:0] != '0)) ? t8[52:45] + 8'd1 : t8[52:45];

    always_comb begin
        s16_val = v_neg_reg ? 16'(-q16) : q16;
        u8      = v_neg_reg ? 10'sd127 - $signed({2'b00, q8})
                            : 10'sd127 + $signed({2'b00, q8});
        if (u8 < 10'sd0) begin
            s8_val = 16'd0;
        end else if (u8 > 10'sd254) begin
            s8_val = 16'd254;
        end else begin
            s8_val = 16'(unsigned'(u8));
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mul_a = 32'(q_cmd.frequency);
                mul_b = 32'(phase_scale);
            end
            ST_SQR: begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            ST_HORNER: begin
                mul_a = 32'(x2_reg);
                mul_b = 32'(h_reg);
            end
            ST_ROOT: begin
                mul_a = 32'(x_reg);
                mul_b = 32'(h_reg);
            end
            ST_BLEND: begin
                mul_a = 32'(wsin);
                mul_b = 32'(s_mag_reg);
            end
            ST_GAIN: begin
                mul_a = m_abs;
                mul_b = 32'(vol_c);
            end
            ST_EMIT: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        tone_left_next  = tone_left_reg;
        pause_left_next = pause_left_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        h_next          = h_reg;
        neg_half_next   = neg_half_reg;
        s_mag_next      = s_mag_reg;
        m_next          = m_reg;
        v_mag_next      = v_mag_reg;
        v_neg_next      = v_neg_reg;
        res_pause_next  = res_pause_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_sample_next   = m_sample_reg;
        m_in_pause_next = m_in_pause_reg;
        m_last_next     = m_last_reg;
        q_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_cmd.is_load) begin
                        phase_acc_next  = '0;
                        phase_step_next = prod[PHASE_BITS-1:0];
                        tone_left_next  = (tone33 > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                               : tone33[COUNT_BITS-1:0];
                        pause_left_next = (pause33 > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                                : pause33[COUNT_BITS-1:0];
                    end else if (tone_left_reg != '0) begin
                        x_next         = 31'(p_adj) << (30 - QB);
                        neg_half_next  = quad[1];
                        phase_acc_next = phase_acc_reg + phase_step_reg;
                        tone_left_next = tone_left_reg - 1'b1;
                        res_pause_next = 1'b0;
                        res_last_next  = (tone_left_reg == COUNT_BITS'(1))
                                         && (pause_left_reg == '0);
                        state_next     = ST_SQR;
                    end else if (pause_left_reg != '0) begin
                        pause_left_next = pause_left_reg - 1'b1;
                        res_pause_next  = 1'b1;
                        res_last_next   = (pause_left_reg == COUNT_BITS'(1));
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_SQR: begin
                x2_next    = prod[60:30];
                h_next     = SQ_C9;
                step_next  = '0;
                state_next = ST_HORNER;
            end
            ST_HORNER: begin
                h_next    = HORNER_COEF[step_reg] - prod[60:30];
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                s_mag_next = (rq > 18'd32768) ? ONE_Q15 : rq[15:0];
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                if (!neg_half_reg && (s_mag_reg != '0)) begin
                    m_next = neg_half_reg ? term_sq - term_sin : term_sq + term_sin;
                end else begin
                    m_next = neg_half_reg ? -term_sq - term_sin : -term_sq + term_sin;
                end
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                v_mag_next = prod[45:0];
                v_neg_next = m_reg[31];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_in_pause_next = res_pause_reg;
                    m_last_next     = res_last_reg;
                    if (res_pause_reg) begin
                        m_sample_next = '0;
                    end else if (sample_format == FMT_S16) begin
                        m_sample_next = $signed(s16_val);
                    end else begin
                        m_sample_next = $signed(s8_val);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            tone_left_reg  <= '0;
            pause_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            tone_left_reg  <= tone_left_next;
            pause_left_reg <= pause_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg       <= step_next;
        x_reg          <= x_next;
        x2_reg         <= x2_next;
        h_reg          <= h_next;
        neg_half_reg   <= neg_half_next;
        s_mag_reg      <= s_mag_next;
        m_reg          <= m_next;
        v_mag_reg      <= v_mag_next;
        v_neg_reg      <= v_neg_next;
        res_pause_reg  <= res_pause_next;
        res_last_reg   <= res_last_next;
        m_sample_reg   <= m_sample_next;
        m_in_pause_reg <= m_in_pause_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_sample   = m_sample_reg;
    assign m_in_pause = m_in_pause_reg;
    assign m_last     = m_last_reg;

    assign back_st.idle          = (state_reg == ST_IDLE);
    assign back_st.tone_pending  = (tone_left_reg != '0);
    assign back_st.pause_pending = (pause_left_reg != '0);

endmodule

FILE: design/square_sine_tone_synth.sv
// channel   ports                           accepted when
// ------    -----                           -------------
// input     s_valid s_ready s_op s_freq..   s_valid && s_ready
// result    m_valid m_ready m_sample ..     m_valid && m_ready
// config    cfg_we cfg_index cfg_wdata      cfg_we
//
// a load, or a tick with nothing pending (no result), ends in the back end's idle
// state; a pause tick goes on to emit, a tone tick through square, horner, root,
// blend, gain and emit: the sine polynomial, blend and gain run one after another
// on a single 32x32 multiplier. reset is synchronous and clears control state,
// counters and config registers; no clearing pass. a 2-deep command queue and the
// output register let input and output stall apart.
// top level of the square/sine tone synthesizer; holds the configuration registers
// depends on sst_pkg, sst_front, sst_back and square_sine_tone_synth_assert.svh
`include "square_sine_tone_synth_assert.svh"

module square_sine_tone_synth
    import sst_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [15:0]           s_frequency,
    input  logic [23:0]           s_tone_length,
    input  logic [23:0]           s_pause_length,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_sample,
    output logic                  m_in_pause,
    output logic                  m_last
);

    logic        sample_format_reg;
    logic [23:0] phase_scale_reg;
    logic [15:0] square_share_reg;
    logic [15:0] volume_reg;

    sst_cmd_t      q_cmd;
    logic          q_valid;
    logic          q_ready;
    sst_front_st_t front_st;
    sst_back_st_t  back_st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_format_reg <= RST_SAMPLE_FORMAT;
            phase_scale_reg   <= RST_PHASE_SCALE;
            square_share_reg  <= RST_SQUARE_SHARE;
            volume_reg        <= RST_VOLUME;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT: sample_format_reg <= cfg_wdata[0];
                REG_PHASE_SCALE:   phase_scale_reg   <= cfg_wdata[23:0];
                REG_SQUARE_SHARE:  square_share_reg  <= cfg_wdata[15:0];
                REG_VOLUME:        volume_reg        <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    sst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_frequency    (s_frequency),
        .s_tone_length  (s_tone_length),
        .s_pause_length (s_pause_length),
        .q_cmd          (q_cmd),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .front_st       (front_st)
    );

    sst_back #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_cmd         (q_cmd),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .sample_format (sample_format_reg),
        .phase_scale   (phase_scale_reg),
        .square_share  (square_share_reg),
        .volume        (volume_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_in_pause    (m_in_pause),
        .m_last        (m_last),
        .back_st       (back_st)
    );

    // pause samples are silent in both formats
    `SST_ASSERT_IMP(a_pause_silent, m_valid && m_in_pause, m_sample == 16'sd0)
    // input stalls only on a full queue
    `SST_ASSERT_IMP(a_stall_full, !s_ready, front_st.level == QUEUE_FULL)
    // the back end pops only when idle
    `SST_ASSERT_IMP(a_pop_idle, q_valid && q_ready, back_st.idle)
    // a load is finished in the cycle it is taken
    `SST_ASSERT_NXT(a_load_done, q_valid && q_ready && q_cmd.is_load, back_st.idle)

endmodule

FILE: test/tone_synth_checker.sv
// scoreboard for the square/sine tone synthesizer: watches the input, result and
// register write ports, predicts every sample and compares it field by field
// depends on sst_pkg for op codes, register indexes, format codes and reset values
`timescale 1ns / 1ps

module tone_synth_checker
    import sst_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_op,
    input  logic [15:0]           s_frequency,
    input  logic [23:0]           s_tone_length,
    input  logic [23:0]           s_pause_length,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [15:0]    m_sample,
    input  logic                  m_in_pause,
    input  logic                  m_last,
    output int                    fail_count,
    output int                    samples_due,
    output int                    samples_checked
);

    localparam int ADDR_SHIFT = 22;     // 32-bit phase, 10-bit table address
    localparam int QUARTER    = 256;
    localparam int X_SHIFT    = 22;     // quarter position to q30
    localparam longint signed UNITY = 32768;

    // odd degree-9 sine polynomial coefficients, q30
    localparam longint unsigned POLY_C1 = 64'd1686629713;
    localparam longint unsigned POLY_C3 = 64'd693598668;
    localparam longint unsigned POLY_C5 = 64'd85569306;
    localparam longint unsigned POLY_C7 = 64'd5026995;
    localparam longint unsigned POLY_C9 = 64'd172272;

    typedef struct {
        logic [15:0] sample;
        logic        in_pause;
        logic        last;
    } tone_out_t;

    tone_out_t expected_samples[$];

    // register copies
    logic        fmt_reg;
    logic [23:0] scale_reg;
    logic [15:0] share_reg;
    logic [15:0] vol_reg;

    // generator state
    logic [31:0] phase;
    logic [31:0] phase_inc;
    logic [23:0] tone_count;
    logic [23:0] pause_count;

    int n_fail;
    int n_checked;

    assign fail_count      = n_fail;
    assign samples_checked = n_checked;

    task automatic report_mismatch(input string what);
        n_fail++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // signed q15 sine, -32768..32768
    function automatic longint signed sine_at(input logic [31:0] ph);
        logic [9:0] addr;
        longint unsigned p, x, x2, h, r;
        addr = ph[31:ADDR_SHIFT];
        p = longint'(addr[7:0]);
        if (addr[8])
            p = QUARTER - p;
        x = p << X_SHIFT;
        x2 = (x * x) >> 30;
        h = POLY_C9;
        h = POLY_C7 - ((x2 * h) >> 30);
        h = POLY_C5 - ((x2 * h) >> 30);
        h = POLY_C3 - ((x2 * h) >> 30);
        h = POLY_C1 - ((x2 * h) >> 30);
        r = (x * h) >> 30;
        r = (r + 64'd16384) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return addr[9] ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [15:0] tone_sample_at(input logic [31:0] ph);
        longint signed s, sq, share, vol, m, v, o;
        longint unsigned mag, prod, q;
        s = sine_at(ph);
        // the square term is low at exactly zero too
        sq = (s > 0) ? UNITY : -UNITY;
        share = (share_reg > 16'd32768) ? UNITY : longint'(share_reg);
        vol = (vol_reg > 16'd32768) ? UNITY : longint'(vol_reg);
        m = share * sq + (UNITY - share) * s;
        v = m * vol;
        mag = (v < 0) ? -v : v;
        if (fmt_reg == FMT_S16) begin
            prod = mag * 64'd32767;
            q = prod >> 45;
            o = (v < 0) ? -longint'(q) : longint'(q);
            if (o > 32767)
                o = 32767;
            if (o < -32768)
                o = -32768;
        end else begin
            prod = mag * 64'd127;
            q = prod >> 45;
            // floor on negative values
            if (v < 0 && prod[44:0] != 0)
                q = q + 1;
            o = 127 + ((v < 0) ? -longint'(q) : longint'(q));
            if (o < 0)
                o = 0;
            if (o > 254)
                o = 254;
        end
        return 16'(o);
    endfunction

    task automatic take_item(input logic op, input logic [15:0] f,
                             input logic [23:0] t, input logic [23:0] p);
        tone_out_t o;
        logic [39:0] prod;
        if (op == OP_LOAD) begin
            prod = 40'(f) * 40'(scale_reg);
            phase = '0;
            phase_inc = prod[31:0];
            tone_count = t;
            pause_count = p;
        end else if (tone_count != 0) begin
            o.sample = tone_sample_at(phase);
            phase = phase + phase_inc;
            tone_count = tone_count - 1;
            o.in_pause = 1'b0;
            o.last = (tone_count == 0 && pause_count == 0);
            expected_samples.push_back(o);
        end else if (pause_count != 0) begin
            pause_count = pause_count - 1;
            o.sample = '0;
            o.in_pause = 1'b1;
            o.last = (pause_count == 0);
            expected_samples.push_back(o);
        end
    endtask

    task automatic check_result();
        tone_out_t e;
        if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with no item waiting for it",
                                      m_sample));
        end else begin
            e = expected_samples.pop_front();
            n_checked++;
            if (m_sample !== e.sample)
                report_mismatch($sformatf("sample got %0d want %0d",
                                          m_sample, $signed(e.sample)));
            if (m_in_pause !== e.in_pause)
                report_mismatch($sformatf("in_pause got %b want %b",
                                          m_in_pause, e.in_pause));
            if (m_last !== e.last)
                report_mismatch($sformatf("last got %b want %b", m_last, e.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_samples.delete();
            fmt_reg = RST_SAMPLE_FORMAT;
            scale_reg = RST_PHASE_SCALE;
            share_reg = RST_SQUARE_SHARE;
            vol_reg = RST_VOLUME;
            phase = '0;
            phase_inc = '0;
            tone_count = '0;
            pause_count = '0;
        end else begin
            // results first: one accepted now belongs to an older item
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                take_item(s_op, s_frequency, s_tone_length, s_pause_length);
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLE_FORMAT: fmt_reg = cfg_wdata[0];
                    REG_PHASE_SCALE:   scale_reg = cfg_wdata[23:0];
                    REG_SQUARE_SHARE:  share_reg = cfg_wdata[15:0];
                    REG_VOLUME:        vol_reg = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        samples_due <= expected_samples.size();
    end

endmodule

FILE: test/tb_top.sv
// top of the tone synthesizer testbench: clock, reset, stimulus, register writes,
// random stalls on both channels and the verdict
// depends on sst_pkg, square_sine_tone_synth and tone_synth_checker
`timescale 1ns / 1ps

module tb_top;
    import sst_pkg::*;

    localparam int N_RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = OP_TICK;
    logic [15:0]           s_frequency = '0;
    logic [23:0]           s_tone_length = '0;
    logic [23:0]           s_pause_length = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [15:0]    m_sample;
    logic                  m_in_pause;
    logic                  m_last;

    int  fail_count;
    int  samples_due;
    int  samples_checked;
    int  n_sent = 0;
    bit  src_quiet = 1'b0;
    bit  sink_quiet = 1'b0;

    square_sine_tone_synth dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_frequency    (s_frequency),
        .s_tone_length  (s_tone_length),
        .s_pause_length (s_pause_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_in_pause     (m_in_pause),
        .m_last         (m_last)
    );

    tone_synth_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_frequency     (s_frequency),
        .s_tone_length   (s_tone_length),
        .s_pause_length  (s_pause_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_in_pause      (m_in_pause),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .samples_due     (samples_due),
        .samples_checked (samples_checked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic idle_for(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_item(input logic op, input logic [15:0] f,
                             input logic [23:0] t, input logic [23:0] p);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_frequency <= f;
        s_tone_length <= t;
        s_pause_length <= p;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        if (!src_quiet && $urandom_range(0, 2) != 0)
            idle_for(pick_gap());
    endtask

    // tick payload is ignored by the block, so it stays random
    task automatic send_tick();
        send_item(OP_TICK, 16'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic wait_samples_out();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (samples_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // register setting for one phase: extremes first, then random ones
    task automatic apply_setting(input int k);
        logic        fmt;
        logic [23:0] scale;
        logic [15:0] share;
        logic [15:0] vol;
        fmt = 1'($urandom);
        scale = 24'($urandom_range(1, 24'hFFFFFF));
        share = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        vol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        case (k)
            0: begin fmt = FMT_U8;  scale = RST_PHASE_SCALE; share = 16'd0; vol = 16'd32768; end
            1: begin fmt = FMT_S16; scale = 24'd1; share = 16'd32768; vol = 16'd32768; end
            2: begin fmt = FMT_U8;  scale = 24'hFFFFFF; share = 16'hFFFF; vol = 16'hFFFF; end
            3: begin fmt = FMT_S16; scale = 24'hFFFFFF; share = 16'd0; vol = 16'd0; end
            4: begin fmt = FMT_U8;  share = 16'd32768; vol = 16'd1; end
            5: begin fmt = FMT_S16; share = 16'd32769; vol = 16'd32769; end
            default: ;
        endcase
        write_reg(REG_SAMPLE_FORMAT, {23'($urandom), fmt});
        write_reg(REG_PHASE_SCALE, scale);
        write_reg(REG_SQUARE_SHARE, {8'($urandom), share});
        write_reg(REG_VOLUME, {8'($urandom), vol});
    endtask

    task automatic random_sequence();
        int          kind;
        int          n_ticks;
        logic [15:0] f;
        logic [23:0] t;
        logic [23:0] p;
        kind = $urandom_range(0, 99);
        f = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        if (kind < 75) begin
            // whole tone and pause, sometimes cut short or ticked past the end
            t = 24'($urandom_range(1, 12));
            p = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 6));
            send_item(OP_LOAD, f, t, p);
            n_ticks = int'(t) + int'(p);
            if ($urandom_range(0, 9) == 0)
                n_ticks = $urandom_range(0, n_ticks - 1);
            else if ($urandom_range(0, 4) == 0)
                n_ticks++;
            repeat (n_ticks) send_tick();
        end else if (kind < 85) begin
            // long tone, replaced by a later load
            send_item(OP_LOAD, f, 24'($urandom), 24'($urandom));
            repeat ($urandom_range(1, 5)) send_tick();
        end else begin
            send_item(1'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
        end
    endtask

    initial begin
        int r;
        int stall;
        forever begin
            r = $urandom_range(1, 12);
            repeat (r) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            if (!sink_quiet) begin
                stall = pick_gap();
                repeat (stall) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int start;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed items under the reset register values
        send_tick();                                    // nothing pending yet
        send_item(OP_LOAD, 16'd1000, 24'd4, 24'd0);     // last falls on a tone sample
        repeat (4) send_tick();
        send_item(OP_LOAD, 16'd0, 24'd2, 24'd1);        // sine stuck at zero
        repeat (3) send_tick();
        send_item(OP_LOAD, 16'd440, 24'd0, 24'd2);      // silence, then pause only
        repeat (3) send_tick();
        send_item(OP_LOAD, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        repeat (2) send_tick();
        send_item(OP_LOAD, 16'd12345, 24'd1, 24'd1);    // load over a running tone
        repeat (2) send_tick();
        send_item(OP_LOAD, 16'd0, 24'd0, 24'd0);        // full silence
        send_tick();

        for (int k = 0; k < N_RANDOM_PHASES; k++) begin
            wait_samples_out();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            apply_setting(k);
            src_quiet = (k == 1);
            sink_quiet = (k == 1 || k == 4);
            start = n_sent;
            while (n_sent - start < ITEMS_PER_PHASE) begin
                random_sequence();
                if ($urandom_range(0, 49) == 0)
                    wait_samples_out();
            end
        end

        wait_samples_out();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("sent %0d items over %0d register settings, %0d samples compared",
                 n_sent, N_RANDOM_PHASES + 1, samples_checked);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/sst_pkg.sv
design/sst_front.sv
design/sst_back.sv
design/square_sine_tone_synth.sv
test/tone_synth_checker.sv
test/tb_top.sv
